[hdl/bqvt_pkg.sv]
// ============================================================================
// bqvt_pkg
// Shared types, codes and helpers for the quorum vote tally core.
// ============================================================================
package bqvt_pkg;

  // Field widths
  localparam int ID_W   = 5;
  localparam int W_W    = 48;
  localparam int SUM_W  = 53;
  localparam int TAG_W  = 64;
  localparam int MASK_W = 32;
  localparam int RESP_W = 6;
  localparam int FUNC_W = 3;

  localparam int NUM_DELEG_DEF = 32;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [RESP_W-1:0] RESP_MAX = {RESP_W{1'b1}};

  // Command queue between front and back
  localparam int QDEPTH = 2;

  // Divide-by-three pipeline: bits retired per stage and stage count
  localparam int DIV_BPS = 8;
  localparam int DIV_STG = (SUM_W + DIV_BPS - 1) / DIV_BPS;
  localparam int DIV_W   = DIV_STG * DIV_BPS;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MY_ID  = 1'd0,
    CFG_STRICT = 1'd1
  } cfg_idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD    = 3'd0,
    FN_START   = 3'd1,
    FN_PREPARE = 3'd2,
    FN_COMMIT  = 3'd3,
    FN_REJECT  = 3'd4,
    FN_TIMER   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_START,
    OP_PREPARE,
    OP_COMMIT,
    OP_REJECT,
    OP_TIMER
  } op_t;

  typedef enum logic [1:0] {
    PH_VOID         = 2'd0,
    PH_PRE_PREPARE  = 2'd1,
    PH_POST_PREPARE = 2'd2,
    PH_POST_COMMIT  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PREPARE = 2'd1,
    ACT_COMMIT  = 2'd2,
    ACT_FAIL    = 2'd3
  } act_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  sender_id;
    logic [W_W-1:0]   vote_amt;
    logic [W_W-1:0]   stake_amt;
    logic [TAG_W-1:0] round_tag;
  } cmd_t;

  // Quorum recompute request and response
  typedef struct packed {
    logic             start;
    logic             strict;
    logic [SUM_W-1:0] vote_total;
    logic [SUM_W-1:0] stake_total;
  } qreq_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] vote_quorum;
    logic [SUM_W-1:0] stake_quorum;
  } qrsp_t;

  // One lane of the long division by three
  typedef struct packed {
    logic [DIV_W-1:0] w;
    logic [DIV_W-1:0] q;
    logic [1:0]       r;
    logic [SUM_W-1:0] tot;
  } div_lane_t;

  typedef struct packed {
    logic      strict;
    div_lane_t vote;
    div_lane_t stake;
  } div_stg_t;

  // Saturating add of a weight into a wide sum
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [W_W-1:0]   b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Retire DIV_BPS bits of a divide by three, MSB first
  function automatic div_lane_t div3_step(input div_lane_t l);
    div_lane_t  o;
    logic [2:0] t;
    logic       qb;
    o = l;
    for (int j = 0; j < DIV_BPS; j++) begin
      t    = {o.r, o.w[DIV_W-1]};
      o.w  = {o.w[DIV_W-2:0], 1'b0};
      qb   = (t >= 3'd3);
      o.r  = qb ? 2'(t - 3'd3) : t[1:0];
      o.q  = {o.q[DIV_W-2:0], qb};
    end
    return o;
  endfunction

endpackage

[hdl/bqvt_front.sv]
// ============================================================================
// bqvt_front
// Accepts input beats and classifies them into back-end commands.
// ============================================================================
module bqvt_front #(
  parameter int NUM_DELEG = bqvt_pkg::NUM_DELEG_DEF
) (
  input  logic [bqvt_pkg::FUNC_W-1:0] func,
  input  logic [bqvt_pkg::ID_W-1:0]   sender_id,
  input  logic [bqvt_pkg::W_W-1:0]    vote_amt,
  input  logic [bqvt_pkg::W_W-1:0]    stake_amt,
  input  logic [bqvt_pkg::TAG_W-1:0]  round_tag,
  input  logic                        sig_valid,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        q_full,
  output logic                        push,
  output bqvt_pkg::cmd_t              cmd
);

  logic id_ok;
  logic msg_ok;

  // Back-pressure comes from the queue only
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign id_ok  = 32'(sender_id) < 32'(NUM_DELEG);
  assign msg_ok = id_ok && sig_valid;

  // Fold range and signature checks into the opcode
  always_comb begin
    cmd.sender_id = sender_id;
    cmd.vote_amt  = vote_amt;
    cmd.stake_amt = stake_amt;
    cmd.round_tag = round_tag;
    case (bqvt_pkg::func_t'(func))
      bqvt_pkg::FN_LOAD:    cmd.op = id_ok  ? bqvt_pkg::OP_LOAD    : bqvt_pkg::OP_NOP;
      bqvt_pkg::FN_START:   cmd.op = bqvt_pkg::OP_START;
      bqvt_pkg::FN_PREPARE: cmd.op = msg_ok ? bqvt_pkg::OP_PREPARE : bqvt_pkg::OP_NOP;
      bqvt_pkg::FN_COMMIT:  cmd.op = msg_ok ? bqvt_pkg::OP_COMMIT  : bqvt_pkg::OP_NOP;
      bqvt_pkg::FN_REJECT:  cmd.op = msg_ok ? bqvt_pkg::OP_REJECT  : bqvt_pkg::OP_NOP;
      bqvt_pkg::FN_TIMER:   cmd.op = bqvt_pkg::OP_TIMER;
      default:              cmd.op = bqvt_pkg::OP_NOP;
    endcase
  end

endmodule

[hdl/bqvt_queue.sv]
// ============================================================================
// bqvt_queue
// Short command FIFO that decouples the front from the back.
// ============================================================================
module bqvt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bqvt_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output bqvt_pkg::cmd_t pop_data
);

  localparam int PTR_W = (bqvt_pkg::QDEPTH > 1) ? $clog2(bqvt_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(bqvt_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(bqvt_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(bqvt_pkg::QDEPTH);

  bqvt_pkg::cmd_t    slots [bqvt_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the payload
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

[hdl/bqvt_quorum.sv]
// ============================================================================
// bqvt_quorum
// Pipelined quorum recompute: 2*floor((total-1)/3)+1, strict or zero cases.
// ============================================================================
module bqvt_quorum (
  input  logic            clk,
  input  logic            rst,
  input  bqvt_pkg::qreq_t req,
  output bqvt_pkg::qrsp_t rsp
);

  localparam int ST = bqvt_pkg::DIV_STG;
  localparam int SW = bqvt_pkg::SUM_W;

  bqvt_pkg::div_stg_t pipe [ST];
  bqvt_pkg::div_stg_t head;
  logic [ST-1:0]      vld;

  function automatic logic [SW-1:0] finish(input bqvt_pkg::div_lane_t l,
                                           input logic strict);
    logic [SW-1:0] res;
    if (l.tot == '0)  res = SW'(1);
    else if (strict)  res = l.tot;
    else              res = {l.q[SW-2:0], 1'b1};
    return res;
  endfunction

  // Seed the division with total minus one
  always_comb begin
    head.strict      = req.strict;
    head.vote.tot    = req.vote_total;
    head.vote.w      = bqvt_pkg::DIV_W'(req.vote_total - SW'(1));
    head.vote.q      = '0;
    head.vote.r      = '0;
    head.stake.tot   = req.stake_total;
    head.stake.w     = bqvt_pkg::DIV_W'(req.stake_total - SW'(1));
    head.stake.q     = '0;
    head.stake.r     = '0;
  end

  // Track occupancy of each stage
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[ST-2:0], req.start};
  end

  // Advance the division stages
  always_ff @(posedge clk) begin
    pipe[0].strict <= head.strict;
    pipe[0].vote   <= bqvt_pkg::div3_step(head.vote);
    pipe[0].stake  <= bqvt_pkg::div3_step(head.stake);
    for (int i = 1; i < ST; i++) begin
      pipe[i].strict <= pipe[i-1].strict;
      pipe[i].vote   <= bqvt_pkg::div3_step(pipe[i-1].vote);
      pipe[i].stake  <= bqvt_pkg::div3_step(pipe[i-1].stake);
    end
  end

  assign rsp.busy         = |vld;
  assign rsp.done         = vld[ST-1];
  assign rsp.vote_quorum  = finish(pipe[ST-1].vote, pipe[ST-1].strict);
  assign rsp.stake_quorum = finish(pipe[ST-1].stake, pipe[ST-1].strict);

endmodule

[hdl/bqvt_back.sv]
// ============================================================================
// bqvt_back
// Executes commands against the round state and registers each result beat.
// ============================================================================
module bqvt_back #(
  parameter int NUM_DELEG = bqvt_pkg::NUM_DELEG_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [bqvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bqvt_pkg::CFG_DATA_W-1:0] cfg_data,
  // command queue
  input  logic                            q_valid,
  input  bqvt_pkg::cmd_t                  cmd,
  output logic                            pop,
  // quorum unit
  output bqvt_pkg::qreq_t                 qreq,
  input  bqvt_pkg::qrsp_t                 qrsp,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      action,
  output logic [1:0]                      phase,
  output logic [bqvt_pkg::MASK_W-1:0]     signer_mask,
  output logic [bqvt_pkg::RESP_W-1:0]     responded_count,
  output logic                            all_responded
);

  localparam int SW     = bqvt_pkg::SUM_W;
  localparam int WW     = bqvt_pkg::W_W;
  localparam int MW     = bqvt_pkg::MASK_W;
  localparam int RW     = bqvt_pkg::RESP_W;
  localparam int WDEPTH = (NUM_DELEG < MW) ? NUM_DELEG : MW;
  localparam int IDX_W  = $clog2(WDEPTH);
  localparam logic [RW-1:0] ALL_RESP = RW'(NUM_DELEG - 1);

  // configuration registers
  logic [bqvt_pkg::ID_W-1:0] self_index;
  logic                      strict_threshold;

  // round state
  bqvt_pkg::phase_t       phase_reg, phase_next;
  logic [WW-1:0]          vote_weights  [WDEPTH];
  logic [WW-1:0]          stake_weights [WDEPTH];
  logic [SW-1:0]          total_vote,   total_vote_next;
  logic [SW-1:0]          total_stake,  total_stake_next;
  logic [SW-1:0]          vote_quorum,  vote_quorum_next;
  logic [SW-1:0]          stake_quorum, stake_quorum_next;
  logic [WW-1:0]          my_vote,      my_vote_next;
  logic [WW-1:0]          my_stake,     my_stake_next;
  logic [SW-1:0]          tally_vote,   tally_vote_next;
  logic [SW-1:0]          tally_stake,  tally_stake_next;
  logic [MW-1:0]          tallied_mask, tallied_mask_next;
  logic [RW-1:0]          responded,    responded_next;
  logic [bqvt_pkg::TAG_W-1:0] current_tag, current_tag_next;
  logic                   timer_armed,  timer_armed_next;
  logic                   timer_phase,  timer_phase_next;

  logic                   is_vote;
  logic                   go;
  logic                   wr_weight;
  logic [IDX_W-1:0]       widx;
  logic [WW-1:0]          rd_vote;
  logic [WW-1:0]          rd_stake;
  logic [MW-1:0]          id_bit;
  logic [MW-1:0]          self_bit;
  bqvt_pkg::act_t         act;
  logic [MW-1:0]          signers;

  // Votes wait while a quorum recompute is in flight
  assign is_vote = (cmd.op == bqvt_pkg::OP_PREPARE) || (cmd.op == bqvt_pkg::OP_COMMIT);
  assign go      = q_valid && (!out_valid || !out_stall) && !(is_vote && qrsp.busy);
  assign pop     = go;

  assign widx     = cmd.sender_id[IDX_W-1:0];
  assign rd_vote  = vote_weights[widx];
  assign rd_stake = stake_weights[widx];
  assign id_bit   = MW'(1) << cmd.sender_id;
  assign self_bit = MW'(1) << self_index;

  // Work out the effect of the command at the head of the queue
  always_comb begin
    bqvt_pkg::phase_t want;
    logic [SW-1:0]    tv;
    logic [SW-1:0]    ts;
    logic [MW-1:0]    mask_n;

    phase_next        = phase_reg;
    total_vote_next   = total_vote;
    total_stake_next  = total_stake;
    my_vote_next      = my_vote;
    my_stake_next     = my_stake;
    tally_vote_next   = tally_vote;
    tally_stake_next  = tally_stake;
    tallied_mask_next = tallied_mask;
    responded_next    = responded;
    current_tag_next  = current_tag;
    timer_armed_next  = timer_armed;
    timer_phase_next  = timer_phase;
    wr_weight         = 1'b0;
    act               = bqvt_pkg::ACT_NONE;
    signers           = '0;
    want = (cmd.op == bqvt_pkg::OP_COMMIT) ? bqvt_pkg::PH_POST_PREPARE
                                           : bqvt_pkg::PH_PRE_PREPARE;
    tv     = tallied_mask[cmd.sender_id] ? tally_vote
                                         : bqvt_pkg::sat_add(tally_vote, rd_vote);
    ts     = tallied_mask[cmd.sender_id] ? tally_stake
                                         : bqvt_pkg::sat_add(tally_stake, rd_stake);
    mask_n = tallied_mask | id_bit;

    if (go) begin
      case (cmd.op)
        bqvt_pkg::OP_LOAD: begin
          wr_weight        = 1'b1;
          total_vote_next  = bqvt_pkg::sat_add(total_vote, cmd.vote_amt);
          total_stake_next = bqvt_pkg::sat_add(total_stake, cmd.stake_amt);
          if (cmd.sender_id == self_index) begin
            my_vote_next  = cmd.vote_amt;
            my_stake_next = cmd.stake_amt;
          end
        end
        bqvt_pkg::OP_START: begin
          current_tag_next  = cmd.round_tag;
          phase_next        = bqvt_pkg::PH_PRE_PREPARE;
          tally_vote_next   = SW'(my_vote);
          tally_stake_next  = SW'(my_stake);
          tallied_mask_next = '0;
          responded_next    = '0;
          timer_armed_next  = 1'b1;
          timer_phase_next  = 1'b0;
        end
        bqvt_pkg::OP_PREPARE, bqvt_pkg::OP_COMMIT, bqvt_pkg::OP_REJECT: begin
          if (phase_reg == want && cmd.round_tag == current_tag) begin
            if (responded != bqvt_pkg::RESP_MAX) responded_next = responded + 1'b1;
            if (cmd.op != bqvt_pkg::OP_REJECT) begin
              tally_vote_next   = tv;
              tally_stake_next  = ts;
              tallied_mask_next = mask_n;
              if (tv >= vote_quorum && ts >= stake_quorum) begin
                signers = mask_n | self_bit;
                if (cmd.op == bqvt_pkg::OP_PREPARE) begin
                  act              = bqvt_pkg::ACT_PREPARE;
                  phase_next       = bqvt_pkg::PH_POST_PREPARE;
                  timer_armed_next = 1'b1;
                  timer_phase_next = 1'b1;
                end else begin
                  act              = bqvt_pkg::ACT_COMMIT;
                  phase_next       = bqvt_pkg::PH_POST_COMMIT;
                  timer_armed_next = 1'b0;
                end
                // restart the tally from this delegate's own weights
                tally_vote_next   = SW'(my_vote);
                tally_stake_next  = SW'(my_stake);
                tallied_mask_next = '0;
                responded_next    = '0;
              end
            end
          end
        end
        bqvt_pkg::OP_TIMER: begin
          if (timer_armed && phase_reg == (timer_phase ? bqvt_pkg::PH_POST_PREPARE
                                                       : bqvt_pkg::PH_PRE_PREPARE)) begin
            act = bqvt_pkg::ACT_FAIL;
          end
          timer_armed_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Kick the quorum unit with the updated totals
  assign qreq.start       = go && (cmd.op == bqvt_pkg::OP_LOAD);
  assign qreq.strict      = strict_threshold;
  assign qreq.vote_total  = total_vote_next;
  assign qreq.stake_total = total_stake_next;

  assign vote_quorum_next  = qrsp.done ? qrsp.vote_quorum  : vote_quorum;
  assign stake_quorum_next = qrsp.done ? qrsp.stake_quorum : stake_quorum;

  // Hold configuration and round state
  always_ff @(posedge clk) begin
    if (rst) begin
      self_index       <= '0;
      strict_threshold <= 1'b0;
      phase_reg        <= bqvt_pkg::PH_VOID;
      total_vote       <= '0;
      total_stake      <= '0;
      vote_quorum      <= SW'(1);
      stake_quorum     <= SW'(1);
      my_vote          <= '0;
      my_stake         <= '0;
      tally_vote       <= '0;
      tally_stake      <= '0;
      tallied_mask     <= '0;
      responded        <= '0;
      current_tag      <= '0;
      timer_armed      <= 1'b0;
      timer_phase      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (bqvt_pkg::cfg_idx_t'(cfg_index))
          bqvt_pkg::CFG_MY_ID:  self_index       <= cfg_data[bqvt_pkg::ID_W-1:0];
          bqvt_pkg::CFG_STRICT: strict_threshold <= cfg_data[0];
          default: ;
        endcase
      end
      phase_reg    <= phase_next;
      total_vote   <= total_vote_next;
      total_stake  <= total_stake_next;
      vote_quorum  <= vote_quorum_next;
      stake_quorum <= stake_quorum_next;
      my_vote      <= my_vote_next;
      my_stake     <= my_stake_next;
      tally_vote   <= tally_vote_next;
      tally_stake  <= tally_stake_next;
      tallied_mask <= tallied_mask_next;
      responded    <= responded_next;
      current_tag  <= current_tag_next;
      timer_armed  <= timer_armed_next;
      timer_phase  <= timer_phase_next;
    end
  end

  // Store delegate weights
  always_ff @(posedge clk) begin
    if (wr_weight) begin
      vote_weights[widx]  <= cmd.vote_amt;
      stake_weights[widx] <= cmd.stake_amt;
    end
  end

  // Result beat: valid until taken
  always_ff @(posedge clk) begin
    if (rst)                      out_valid <= 1'b0;
    else if (go)                  out_valid <= 1'b1;
    else if (!out_stall)          out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      action          <= act;
      phase           <= phase_next;
      signer_mask     <= signers;
      responded_count <= responded_next;
      all_responded   <= (responded_next == ALL_RESP);
    end
  end

endmodule

[hdl/bft_quorum_vote_tally_core.sv]
// ============================================================================
// bft_quorum_vote_tally_core
// Primary-side quorum tally for one consensus round: weight loading, round
// start, prepare/commit tallying, rejection counting and timeout reporting.
// ============================================================================
//  Channel   Handshake                  Beat contents
//  --------  -------------------------  ---------------------------------------
//  input     in_valid / in_stall        func, sender_id, vote_amt,
//                                       stake_amt, round_tag, sig_valid
//  result    out_valid / out_stall      action, phase, signer_mask,
//                                       responded_count, all_responded
//  config    cfg_wr_en                  cfg_index, cfg_data (no read-back)
//
//  One result beat per input beat, in order; one beat per cycle when both
//  sides flow. A load starts a seven-stage divide-by-three pipeline for the
//  quorums; a prepare or commit that reaches the back while it is in flight
//  waits until the pipeline has emptied. A two-entry command queue sits
//  between the front and the back; the result register holds a beat until
//  taken, and the back takes no new command while a beat waits.
//  Reset is synchronous; delegate weight storage is not cleared by it.
// ============================================================================
module bft_quorum_vote_tally_core #(
  parameter int NUM_DELEG = bqvt_pkg::NUM_DELEG_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [bqvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bqvt_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bqvt_pkg::FUNC_W-1:0]     func,
  input  logic [bqvt_pkg::ID_W-1:0]       sender_id,
  input  logic [bqvt_pkg::W_W-1:0]        vote_amt,
  input  logic [bqvt_pkg::W_W-1:0]        stake_amt,
  input  logic [bqvt_pkg::TAG_W-1:0]      round_tag,
  input  logic                            sig_valid,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      action,
  output logic [1:0]                      phase,
  output logic [bqvt_pkg::MASK_W-1:0]     signer_mask,
  output logic [bqvt_pkg::RESP_W-1:0]     responded_count,
  output logic                            all_responded
);

  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  bqvt_pkg::cmd_t  front_cmd;
  bqvt_pkg::cmd_t  back_cmd;
  bqvt_pkg::qreq_t qreq;
  bqvt_pkg::qrsp_t qrsp;

  bqvt_front #(
    .NUM_DELEG (NUM_DELEG)
  ) u_front (
    .func      (func),
    .sender_id (sender_id),
    .vote_amt  (vote_amt),
    .stake_amt (stake_amt),
    .round_tag (round_tag),
    .sig_valid (sig_valid),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .cmd       (front_cmd)
  );

  bqvt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (back_cmd)
  );

  bqvt_quorum u_quorum (
    .clk (clk),
    .rst (rst),
    .req (qreq),
    .rsp (qrsp)
  );

  bqvt_back #(
    .NUM_DELEG (NUM_DELEG)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .cmd             (back_cmd),
    .pop             (pop),
    .qreq            (qreq),
    .qrsp            (qrsp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .action          (action),
    .phase           (phase),
    .signer_mask     (signer_mask),
    .responded_count (responded_count),
    .all_responded   (all_responded)
  );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Quorum vote tally core testbench
// Drives load, round start, prepare, commit, rejection and timer messages
// through the core under several register settings and idle patterns, and
// compares each result beat field by field against an in-bench tally
// predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic [bqvt_pkg::FUNC_W-1:0] fn;
  logic [bqvt_pkg::ID_W-1:0]   id;
  logic [bqvt_pkg::W_W-1:0]    vw;
  logic [bqvt_pkg::W_W-1:0]    sw;
  logic [bqvt_pkg::TAG_W-1:0]  tag;
  logic                        sv;
} vote_msg_t;

typedef struct {
  logic [1:0]                  act;
  logic [1:0]                  stage;
  logic [bqvt_pkg::MASK_W-1:0] mask;
  logic [bqvt_pkg::RESP_W-1:0] replies;
  logic                        full;
} verdict_t;

// Tally predictor plus the queue of result beats it still owes
class quorum_tally_board;
  logic [bqvt_pkg::ID_W-1:0]   self_id;
  logic                        strict_mode;
  logic [1:0]                  ph;
  logic [bqvt_pkg::W_W-1:0]    vote_w[bqvt_pkg::NUM_DELEG_DEF];
  logic [bqvt_pkg::W_W-1:0]    stake_w[bqvt_pkg::NUM_DELEG_DEF];
  logic [bqvt_pkg::SUM_W-1:0]  tot_v, tot_s, need_v, need_s, tally_v, tally_s;
  logic [bqvt_pkg::W_W-1:0]    own_v, own_s;
  logic [bqvt_pkg::MASK_W-1:0] signed_by;
  logic [bqvt_pkg::RESP_W-1:0] replies;
  logic [bqvt_pkg::TAG_W-1:0]  round_id;
  logic                        armed, armed_commit;
  int                          errors;
  verdict_t                    due_results[$];

  function new();
    self_id      = '0;
    strict_mode  = 1'b0;
    ph           = bqvt_pkg::PH_VOID;
    tot_v        = '0;
    tot_s        = '0;
    need_v       = bqvt_pkg::SUM_W'(1);
    need_s       = bqvt_pkg::SUM_W'(1);
    own_v        = '0;
    own_s        = '0;
    tally_v      = '0;
    tally_s      = '0;
    signed_by    = '0;
    replies      = '0;
    round_id     = '0;
    armed        = 1'b0;
    armed_commit = 1'b0;
    errors       = 0;
    foreach (vote_w[i]) begin
      vote_w[i]  = '0;
      stake_w[i] = '0;
    end
  endfunction

  function void set_register(bqvt_pkg::cfg_idx_t idx,
                             logic [bqvt_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bqvt_pkg::CFG_MY_ID:  self_id = val;
      bqvt_pkg::CFG_STRICT: strict_mode = val[0];
      default: ;
    endcase
  endfunction

  function logic [bqvt_pkg::SUM_W-1:0] add_capped(logic [bqvt_pkg::SUM_W-1:0] a,
                                                  logic [bqvt_pkg::W_W-1:0] b);
    logic [bqvt_pkg::SUM_W:0] s;
    s = {1'b0, a} + (bqvt_pkg::SUM_W+1)'(b);
    return s[bqvt_pkg::SUM_W] ? bqvt_pkg::SUM_MAX : s[bqvt_pkg::SUM_W-1:0];
  endfunction

  function logic [bqvt_pkg::SUM_W-1:0] quorum_for(logic [bqvt_pkg::SUM_W-1:0] t);
    if (t == '0) return bqvt_pkg::SUM_W'(1);
    if (strict_mode) return t;
    return ((t - bqvt_pkg::SUM_W'(1)) / bqvt_pkg::SUM_W'(3)) * bqvt_pkg::SUM_W'(2)
           + bqvt_pkg::SUM_W'(1);
  endfunction

  function void restart();
    tally_v   = bqvt_pkg::SUM_W'(own_v);
    tally_s   = bqvt_pkg::SUM_W'(own_s);
    signed_by = '0;
    replies   = '0;
  endfunction

  // Advance the tally by one accepted message and queue the beat it owes
  function void accept(vote_msg_t m);
    verdict_t                    v;
    logic [1:0]                  want;
    logic [bqvt_pkg::MASK_W-1:0] bit_m;
    v.act  = bqvt_pkg::ACT_NONE;
    v.mask = '0;
    case (m.fn)
      bqvt_pkg::FN_LOAD: begin
        vote_w[m.id]  = m.vw;
        stake_w[m.id] = m.sw;
        tot_v = add_capped(tot_v, m.vw);
        tot_s = add_capped(tot_s, m.sw);
        if (m.id == self_id) begin
          own_v = m.vw;
          own_s = m.sw;
        end
        need_v = quorum_for(tot_v);
        need_s = quorum_for(tot_s);
      end
      bqvt_pkg::FN_START: begin
        round_id = m.tag;
        ph       = bqvt_pkg::PH_PRE_PREPARE;
        restart();
        armed        = 1'b1;
        armed_commit = 1'b0;
      end
      bqvt_pkg::FN_PREPARE, bqvt_pkg::FN_COMMIT, bqvt_pkg::FN_REJECT: begin
        want = (m.fn == bqvt_pkg::FN_COMMIT) ? bqvt_pkg::PH_POST_PREPARE
                                             : bqvt_pkg::PH_PRE_PREPARE;
        if (m.sv && ph == want && m.tag == round_id) begin
          if (replies != bqvt_pkg::RESP_MAX) replies++;
          if (m.fn != bqvt_pkg::FN_REJECT) begin
            // add each sender's weight once per phase
            bit_m = bqvt_pkg::MASK_W'(1) << m.id;
            if ((signed_by & bit_m) == '0) begin
              tally_v   = add_capped(tally_v, vote_w[m.id]);
              tally_s   = add_capped(tally_s, stake_w[m.id]);
              signed_by = signed_by | bit_m;
            end
            if (tally_v >= need_v && tally_s >= need_s) begin
              v.mask = signed_by | (bqvt_pkg::MASK_W'(1) << self_id);
              if (m.fn == bqvt_pkg::FN_PREPARE) begin
                v.act        = bqvt_pkg::ACT_PREPARE;
                ph           = bqvt_pkg::PH_POST_PREPARE;
                armed        = 1'b1;
                armed_commit = 1'b1;
              end else begin
                v.act = bqvt_pkg::ACT_COMMIT;
                ph    = bqvt_pkg::PH_POST_COMMIT;
                armed = 1'b0;
              end
              restart();
            end
          end
        end
      end
      bqvt_pkg::FN_TIMER: begin
        if (armed && ph == (armed_commit ? bqvt_pkg::PH_POST_PREPARE
                                         : bqvt_pkg::PH_PRE_PREPARE))
          v.act = bqvt_pkg::ACT_FAIL;
        armed = 1'b0;
      end
      default: ;
    endcase
    v.stage   = ph;
    v.replies = replies;
    v.full    = (replies == bqvt_pkg::RESP_W'(bqvt_pkg::NUM_DELEG_DEF - 1));
    due_results.insert(due_results.size(), v);
  endfunction

  function void field_check(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [1:0] act, logic [1:0] stage,
                             logic [bqvt_pkg::MASK_W-1:0] mask,
                             logic [bqvt_pkg::RESP_W-1:0] resp, logic full);
    verdict_t want;
    if (due_results.size() == 0) begin
      $error("result beat with no message waiting");
      errors++;
      return;
    end
    want = due_results.pop_front();
    field_check("action", 64'(want.act), 64'(act));
    field_check("phase", 64'(want.stage), 64'(stage));
    field_check("signer_mask", 64'(want.mask), 64'(mask));
    field_check("responded_count", 64'(want.replies), 64'(resp));
    field_check("all_responded", 64'(want.full), 64'(full));
  endfunction
endclass

module tb;

  localparam logic [bqvt_pkg::FUNC_W-1:0] FN_UNUSED6 = 3'd6;
  localparam logic [bqvt_pkg::FUNC_W-1:0] FN_UNUSED7 = 3'd7;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [bqvt_pkg::CFG_IDX_W-1:0]  cfg_index = bqvt_pkg::CFG_MY_ID;
  logic [bqvt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [bqvt_pkg::FUNC_W-1:0]     func = '0;
  logic [bqvt_pkg::ID_W-1:0]       sender_id = '0;
  logic [bqvt_pkg::W_W-1:0]        vote_amt = '0;
  logic [bqvt_pkg::W_W-1:0]        stake_amt = '0;
  logic [bqvt_pkg::TAG_W-1:0]      round_tag = '0;
  logic                            sig_valid = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      action;
  logic [1:0]                      phase;
  logic [bqvt_pkg::MASK_W-1:0]     signer_mask;
  logic [bqvt_pkg::RESP_W-1:0]     responded_count;
  logic                            all_responded;

  quorum_tally_board sb = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int w_lo = 0;
  int w_hi = 0;
  bit loads_in_noise = 1'b0;
  int sent = 0;

  bft_quorum_vote_tally_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check each result beat taken
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(action, phase, signer_mask, responded_count, all_responded);
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [bqvt_pkg::W_W-1:0] rand48();
    return bqvt_pkg::W_W'({$urandom, $urandom});
  endfunction

  function automatic logic [bqvt_pkg::TAG_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Weight with its top set bit in the current range, or all ones
  function automatic logic [bqvt_pkg::W_W-1:0] pick_weight();
    logic [bqvt_pkg::W_W-1:0] w;
    int                       lg;
    if (w_hi >= bqvt_pkg::W_W) return '1;
    lg = $urandom_range(w_lo, w_hi);
    w  = rand48() & ((bqvt_pkg::W_W'(1) << lg) - bqvt_pkg::W_W'(1));
    return w | (bqvt_pkg::W_W'(1) << lg);
  endfunction

  function automatic logic [bqvt_pkg::TAG_W-1:0] fresh_tag();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  // Hold one input beat until taken, after a random gap
  task automatic put_beat(input logic [bqvt_pkg::FUNC_W-1:0] fn,
                          input logic [bqvt_pkg::ID_W-1:0] id,
                          input logic [bqvt_pkg::W_W-1:0] vw,
                          input logic [bqvt_pkg::W_W-1:0] sw,
                          input logic [bqvt_pkg::TAG_W-1:0] tag, input logic sv);
    vote_msg_t m;
    int        gap;
    m.fn  = fn;
    m.id  = id;
    m.vw  = vw;
    m.sw  = sw;
    m.tag = tag;
    m.sv  = sv;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= fn;
    sender_id <= id;
    vote_amt  <= vw;
    stake_amt <= sw;
    round_tag <= tag;
    sig_valid <= sv;
    do @(posedge clk); while (in_stall);
    sb.accept(m);
    sent++;
  endtask

  task automatic put_msg(input logic [bqvt_pkg::FUNC_W-1:0] fn,
                         input logic [bqvt_pkg::ID_W-1:0] id,
                         input logic [bqvt_pkg::TAG_W-1:0] tag, input logic sv);
    put_beat(fn, id, rand48(), rand48(), tag, sv);
  endtask

  // Drop valid and wait until every owed beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  // Write both registers once the quorum divider has settled
  task automatic configure(input logic [bqvt_pkg::ID_W-1:0] self_id, input logic strict);
    repeat (16) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= bqvt_pkg::CFG_MY_ID;
    cfg_data  <= self_id;
    @(posedge clk);
    cfg_index <= bqvt_pkg::CFG_STRICT;
    cfg_data  <= bqvt_pkg::CFG_DATA_W'(strict);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_register(bqvt_pkg::CFG_MY_ID, self_id);
    sb.set_register(bqvt_pkg::CFG_STRICT, bqvt_pkg::CFG_DATA_W'(strict));
  endtask

  // One off-path or malformed message
  task automatic noise();
    logic [bqvt_pkg::TAG_W-1:0] cur;
    cur = sb.round_id;
    case ($urandom_range(0, 9))
      0: put_msg(bqvt_pkg::FN_PREPARE, 5'($urandom),
                 cur ^ (64'd1 << $urandom_range(0, 63)), 1'b1);
      1: put_msg(bqvt_pkg::FN_COMMIT, 5'($urandom), cur, 1'b0);
      2: put_msg($urandom_range(0, 1) ? bqvt_pkg::FN_PREPARE : bqvt_pkg::FN_COMMIT,
                 5'($urandom), cur, 1'b1);
      3: put_msg(bqvt_pkg::FN_REJECT, 5'($urandom), cur, 1'b1);
      4: put_msg(bqvt_pkg::FN_REJECT, 5'($urandom),
                 $urandom_range(0, 1) ? cur : rand64(), 1'b0);
      5: put_msg(bqvt_pkg::FN_TIMER, 5'($urandom), rand64(), 1'($urandom));
      6: put_msg($urandom_range(0, 1) ? FN_UNUSED6 : FN_UNUSED7, 5'($urandom), rand64(),
                 1'($urandom));
      7: begin
        if (loads_in_noise)
          put_beat(bqvt_pkg::FN_LOAD, 5'($urandom), pick_weight(), pick_weight(),
                   rand64(), 1'($urandom));
        else
          put_msg(bqvt_pkg::FN_REJECT, 5'($urandom), cur, 1'b1);
      end
      8: put_msg(3'($urandom_range(1, 7)), 5'($urandom), rand64(), 1'($urandom));
      default: put_msg(bqvt_pkg::FN_REJECT, 5'($urandom), cur, 1'b1);
    endcase
  endtask

  // Votes from every delegate in shuffled order until the phase moves on
  task automatic vote_stage(input logic [bqvt_pkg::FUNC_W-1:0] fn, input logic [1:0] need);
    int order[bqvt_pkg::NUM_DELEG_DEF];
    int j, t;
    for (int i = 0; i < bqvt_pkg::NUM_DELEG_DEF; i++) order[i] = i;
    for (int i = bqvt_pkg::NUM_DELEG_DEF - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < bqvt_pkg::NUM_DELEG_DEF && sb.ph == need; i++) begin
      if ($urandom_range(0, 99) < 15) noise();
      // resend an earlier sender now and then
      if ($urandom_range(0, 99) < 10)
        put_msg(fn, 5'(order[$urandom_range(0, i)]), sb.round_id, 1'b1);
      if (sb.ph == need) put_msg(fn, 5'(order[i]), sb.round_id, 1'b1);
    end
  endtask

  task automatic episode();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // full round: prepare, then commit
      put_msg(bqvt_pkg::FN_START, 5'($urandom), fresh_tag(), 1'($urandom));
      vote_stage(bqvt_pkg::FN_PREPARE, bqvt_pkg::PH_PRE_PREPARE);
      if (sb.ph == bqvt_pkg::PH_POST_PREPARE) begin
        if ($urandom_range(0, 99) < 20)
          put_msg(bqvt_pkg::FN_TIMER, 5'($urandom), rand64(), 1'b1);
        vote_stage(bqvt_pkg::FN_COMMIT, bqvt_pkg::PH_POST_PREPARE);
      end
      if ($urandom_range(0, 99) < 40)
        put_msg(bqvt_pkg::FN_TIMER, 5'($urandom), rand64(), 1'b1);
    end else if (pick < 85) begin
      // rejection flood can drive the response count to its cap
      put_msg(bqvt_pkg::FN_START, 5'($urandom), fresh_tag(), 1'b1);
      repeat ($urandom_range(20, 70)) begin
        if ($urandom_range(0, 99) < 10) noise();
        put_msg(bqvt_pkg::FN_REJECT, 5'($urandom), sb.round_id, 1'b1);
      end
      put_msg(bqvt_pkg::FN_TIMER, 5'($urandom), rand64(), 1'b1);
    end else begin
      repeat (8) noise();
    end
    if ($urandom_range(0, 9) == 0) drain_results();
  endtask

  task automatic run_setting(input logic [bqvt_pkg::ID_W-1:0] self_id, input logic strict,
                             input int idle, input int stall, input int lg_lo,
                             input int lg_hi, input logic [31:0] preload, input int reps,
                             input bit noisy_loads);
    int first;
    drain_results();
    configure(self_id, strict);
    idle_pct       = idle;
    stall_pct      = stall;
    w_lo           = lg_lo;
    w_hi           = lg_hi;
    loads_in_noise = noisy_loads;
    repeat (reps) begin
      for (int d = 0; d < bqvt_pkg::NUM_DELEG_DEF; d++)
        if (preload[d])
          put_beat(bqvt_pkg::FN_LOAD, 5'(d), pick_weight(), pick_weight(), rand64(),
                   1'($urandom));
    end
    first = sent;
    while (sent - first < 80) episode();
  endtask

  task automatic directed();
    logic [bqvt_pkg::TAG_W-1:0] t;
    t = '1;
    // round with no weights loaded: own tally zero against quorum one
    put_msg(bqvt_pkg::FN_START, 5'd0, 64'd0, 1'b1);
    put_msg(bqvt_pkg::FN_TIMER, 5'd0, 64'd0, 1'b1);
    put_msg(bqvt_pkg::FN_TIMER, 5'd31, 64'd0, 1'b1);
    put_msg(FN_UNUSED6, 5'd31, '1, 1'b1);
    put_msg(FN_UNUSED7, 5'd0, 64'd0, 1'b0);
    // zero total keeps quorum at one
    put_beat(bqvt_pkg::FN_LOAD, 5'd3, '0, '0, 64'd0, 1'b0);
    put_beat(bqvt_pkg::FN_LOAD, 5'd0, 48'd5, 48'd7, 64'd0, 1'b1);
    put_beat(bqvt_pkg::FN_LOAD, 5'd31, 48'd10, 48'd2, '1, 1'b1);
    put_msg(bqvt_pkg::FN_START, 5'd0, t, 1'b1);
    // bad signature, wrong tag, commit in pre-prepare
    put_msg(bqvt_pkg::FN_PREPARE, 5'd31, t, 1'b0);
    put_msg(bqvt_pkg::FN_PREPARE, 5'd31, t ^ 64'd1, 1'b1);
    put_msg(bqvt_pkg::FN_COMMIT, 5'd31, t, 1'b1);
    put_msg(bqvt_pkg::FN_REJECT, 5'd3, t, 1'b1);
    // zero-weight sender, then the same sender again
    put_msg(bqvt_pkg::FN_PREPARE, 5'd3, t, 1'b1);
    put_msg(bqvt_pkg::FN_PREPARE, 5'd3, t, 1'b1);
    put_msg(bqvt_pkg::FN_PREPARE, 5'd31, t, 1'b1);
    put_msg(bqvt_pkg::FN_TIMER, 5'd0, t, 1'b1);
    put_msg(bqvt_pkg::FN_COMMIT, 5'd3, t, 1'b1);
    put_msg(bqvt_pkg::FN_COMMIT, 5'd31, t, 1'b1);
    put_msg(bqvt_pkg::FN_TIMER, 5'd0, t, 1'b1);
    // late votes after commit
    put_msg(bqvt_pkg::FN_PREPARE, 5'd31, t, 1'b1);
    put_msg(bqvt_pkg::FN_REJECT, 5'd0, t, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    directed();
    // strict over small added weights: every delegate with weight must sign
    run_setting(5'd31, 1'b1, 0, 0, 0, 9, 32'h7FFF_FFF6, 1, 1'b0);
    run_setting(5'd31, 1'b0, 47, 0, 18, 21, 32'hFFFF_FFFF, 1, 1'b1);
    run_setting(5'd0, 1'b0, 0, 47, 30, 33, 32'hFFFF_FFFF, 1, 1'b1);
    // strict set without a load keeps the old quorums until one comes
    run_setting(5'd17, 1'b1, 36, 36, 30, 33, 32'h0000_0000, 0, 1'b1);
    // full-scale weights twice over saturate the totals
    run_setting(5'd31, 1'b0, 0, 0, bqvt_pkg::W_W, bqvt_pkg::W_W, 32'hFFFF_FFFF, 2, 1'b1);
    run_setting(5'd5, 1'b1, 36, 36, bqvt_pkg::W_W, bqvt_pkg::W_W, 32'h0000_0020, 1, 1'b1);
    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
hdl/bqvt_pkg.sv
hdl/bqvt_front.sv
hdl/bqvt_queue.sv
hdl/bqvt_quorum.sv
hdl/bqvt_back.sv
hdl/bft_quorum_vote_tally_core.sv
bench/tb.sv
